/* src/dnle_pkg.sv */
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

  // Characters with a meaning of their own in the dotted name
  localparam logic [7:0] DOT_CHAR = 8'd46;
  localparam logic [7:0] NUL_CHAR = 8'd0;

  // Capacity register value after reset
  localparam logic [15:0] CAPACITY_RESET = 16'd512;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,   // taking characters
    ST_CHARS,  // streaming stored label characters out
    ST_TERM    // sending the terminating zero byte
  } dnle_state_t;

endpackage

/* src/dns_name_label_encoder_top.sv */
// ----------------------------------------------------------------------------
// dns_name_label_encoder_top
// Turns a dotted name, one character per beat and closed by a zero character,
// into length-prefixed DNS labels, with capacity and label-length checks.
// ----------------------------------------------------------------------------
// An ordinary character is written into the label store and gives no output
// beat. For a dot or the closing zero, the length byte is registered when the
// character is taken; then the stored characters are read back from the label
// store through its single read port, one per cycle while the output does not
// stall; then, for a closing zero after a non-empty label, the terminating
// zero. An overflow gives a single error beat, after which, unless the
// overflowing character was the closing zero, characters are swallowed, one per
// cycle while the output does not stall, up to the closing zero. The label
// store holds LABEL_MAX bytes and needs no clearing after reset; the
// capacity register resets to 512 and should only be written while idle.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_top #(
  parameter int LABEL_MAX = 62
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  // character input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  name_char,
  // encoded output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        name_done,
  output logic        overflow_error
);

  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int FW = $clog2(LABEL_MAX + 1);

  // Registers
  dnle_pkg::dnle_state_t state, state_next;
  logic [15:0]    capacity;
  logic [FW-1:0]  label_fill, label_fill_next;
  logic [16:0]    bytes_used, bytes_used_next;
  logic           abandoned, abandoned_next;
  logic           emit_nul, emit_nul_next;
  logic [AW-1:0]  rd_idx, rd_idx_next;
  logic           out_valid_next;
  logic [7:0]     out_byte_next;
  logic           run_last_next, name_done_next, overflow_error_next;

  // Label store
  logic [7:0]     label_store [LABEL_MAX];
  logic [7:0]     rd_data;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr;

  // Decode and checks
  logic           acc, slot_free, is_nul, is_dot, char_last;
  logic [17:0]    pending;
  logic           err_nul, err_dot, err_chr;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != dnle_pkg::ST_IDLE) || !slot_free;
  assign acc       = in_valid && !in_stall;
  assign is_nul    = (name_char == dnle_pkg::NUL_CHAR);
  assign is_dot    = (name_char == dnle_pkg::DOT_CHAR);

  // Bytes taken once the pending length byte and stored characters go out
  assign pending = {1'b0, bytes_used} + 18'd1 + 18'(label_fill);
  assign err_nul = (pending + 18'(label_fill != '0)) > 18'(capacity);
  assign err_dot = (pending + 18'd1) > 18'(capacity);
  assign err_chr = (label_fill >= FW'(LABEL_MAX)) || ((pending + 18'd2) > 18'(capacity));

  // Final stored character of the label being streamed
  assign char_last = ((FW+1)'(rd_idx) + (FW+1)'(1)) == (FW+1)'(label_fill);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dnle_pkg::ST_IDLE: begin
        if (acc && !abandoned && label_fill != '0 &&
            ((is_nul && !err_nul) || (is_dot && !err_dot))) begin
          state_next = dnle_pkg::ST_CHARS;
        end
      end
      dnle_pkg::ST_CHARS: begin
        if (slot_free && char_last) begin
          state_next = emit_nul ? dnle_pkg::ST_TERM : dnle_pkg::ST_IDLE;
        end
      end
      dnle_pkg::ST_TERM: begin
        if (slot_free) begin
          state_next = dnle_pkg::ST_IDLE;
        end
      end
      default: state_next = dnle_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output beat
  always_comb begin
    label_fill_next     = label_fill;
    bytes_used_next     = bytes_used;
    abandoned_next      = abandoned;
    emit_nul_next       = emit_nul;
    rd_idx_next         = rd_idx;
    rd_en               = 1'b0;
    rd_addr             = '0;
    wr_en               = 1'b0;
    out_valid_next      = out_valid && out_stall;
    out_byte_next       = out_byte;
    run_last_next       = run_last;
    name_done_next      = name_done;
    overflow_error_next = overflow_error;
    case (state)
      dnle_pkg::ST_IDLE: begin
        if (acc) begin
          if (abandoned) begin
            // swallow until the closing zero
            if (is_nul) begin
              label_fill_next = '0;
              bytes_used_next = '0;
              abandoned_next  = 1'b0;
            end
          end else if ((is_nul && err_nul) || (is_dot && err_dot) ||
                       (!is_nul && !is_dot && err_chr)) begin
            // overflow: one error beat ends the name
            label_fill_next     = '0;
            bytes_used_next     = '0;
            abandoned_next      = !is_nul;
            out_valid_next      = 1'b1;
            out_byte_next       = '0;
            run_last_next       = 1'b1;
            name_done_next      = 1'b1;
            overflow_error_next = 1'b1;
          end else if (is_nul || is_dot) begin
            // length byte now, characters follow
            out_valid_next      = 1'b1;
            out_byte_next       = 8'(label_fill);
            run_last_next       = (label_fill == '0);
            name_done_next      = is_nul && (label_fill == '0);
            overflow_error_next = 1'b0;
            emit_nul_next       = is_nul;
            rd_idx_next         = '0;
            rd_en               = (label_fill != '0);
            if (is_nul) begin
              if (label_fill == '0) begin
                bytes_used_next = '0;
              end
            end else begin
              bytes_used_next = pending[16:0];
            end
          end else begin
            wr_en           = 1'b1;
            label_fill_next = label_fill + FW'(1);
          end
        end
      end
      dnle_pkg::ST_CHARS: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          out_byte_next       = rd_data;
          run_last_next       = char_last && !emit_nul;
          name_done_next      = 1'b0;
          overflow_error_next = 1'b0;
          if (char_last) begin
            if (!emit_nul) begin
              label_fill_next = '0;
            end
          end else begin
            rd_en       = 1'b1;
            rd_addr     = rd_idx + AW'(1);
            rd_idx_next = rd_idx + AW'(1);
          end
        end
      end
      dnle_pkg::ST_TERM: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          out_byte_next       = '0;
          run_last_next       = 1'b1;
          name_done_next      = 1'b1;
          overflow_error_next = 1'b0;
          label_fill_next     = '0;
          bytes_used_next     = '0;
        end
      end
      default: begin
        out_valid_next = out_valid_next;
      end
    endcase
  end

  // Label store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      label_store[label_fill[AW-1:0]] <= name_char;
    end
    if (rd_en) begin
      rd_data <= label_store[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dnle_pkg::ST_IDLE;
      capacity   <= dnle_pkg::CAPACITY_RESET;
      label_fill <= '0;
      bytes_used <= '0;
      abandoned  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      label_fill <= label_fill_next;
      bytes_used <= bytes_used_next;
      abandoned  <= abandoned_next;
      out_valid  <= out_valid_next;
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    emit_nul       <= emit_nul_next;
    rd_idx         <= rd_idx_next;
    out_byte       <= out_byte_next;
    run_last       <= run_last_next;
    name_done      <= name_done_next;
    overflow_error <= overflow_error_next;
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    label_fill <= FW'(LABEL_MAX))
    else $error("label fill beyond store depth");

  a_chars_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == dnle_pkg::ST_CHARS |-> label_fill != '0)
    else $error("streaming an empty label");

  a_err_ends_name: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow_error |-> run_last && name_done && out_byte == '0)
    else $error("error beat does not end the name");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && name_done |-> run_last)
    else $error("name end without end of run");

  a_no_store_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("label store written and read together");

endmodule
